FILE: design/first_fit_free_list_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the free-list allocator
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// The condition never holds.
`define FFA_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("allocator assertion failed");

// The antecedent implies the consequent in the same cycle.
`define FFA_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// The antecedent implies the consequent in the next cycle.
`define FFA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

FILE: design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants shared by the free-list allocator modules.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int POOL_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int OPCODE_W  = 1;
    localparam int REQ_W     = 13;
    localparam int UOFF_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int GRANT_W   = 12;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic sz_we;
        logic nx_we;
    } mem_ctl_t;

endpackage

FILE: design/ffa_req_if.sv
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel: valid, ready and one allocate or free item.
// ----------------------------------------------------------------------------
interface ffa_req_if;
    import ffa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [REQ_W-1:0]    request_bytes;
    logic [UOFF_W-1:0]   user_offset;

    modport source (output valid, opcode, request_bytes, user_offset, input ready);
    modport sink   (input valid, opcode, request_bytes, user_offset, output ready);
endinterface

FILE: design/ffa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
    import ffa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_offset;

    modport source (output valid, status, granted_offset, input ready);
    modport sink   (input valid, status, granted_offset, output ready);
endinterface

FILE: design/first_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// First-fit allocator over an address-ordered free list, with coalescing.
//
//   Channel  Dir  Payload                                   Item accepted when
//   req      in   opcode, request_bytes, user_offset        req.valid & req.ready
//   rsp      out  status, granted_offset                    rsp.valid & rsp.ready
//
// An allocate reads the head block and walks the free list to the first fit, with a
// split step when the block splits; a zero-size allocate or an allocate on an empty
// list goes straight to the done state. A free at the head is linked in at once, one
// elsewhere is walked to its place and linked in; both then run a coalescing pass over
// the free list. An ignored free goes to done at once or after its walk. Walks read
// headers through the single header read port. No clearing pass follows reset. One
// request is in work at a time; a finished result waits in the done state while the
// previous one is still held at the output.
module first_fit_free_list_allocator_core #(
    parameter int POOL_BYTES   = ffa_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ffa_req_if.sink    req,
    ffa_rsp_if.source  rsp
);
    import ffa_pkg::*;

    localparam int AW = $clog2(POOL_BYTES);
    localparam int LW = AW + 1;

    mem_ctl_t            ctl;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       sz_waddr;
    logic [LW-1:0]       sz_wdata;
    logic [AW-1:0]       nx_waddr;
    logic [LW-1:0]       nx_wdata;
    logic [LW-1:0]       rd_size;
    logic [LW-1:0]       rd_link;
    logic                res_valid;
    logic                res_ready;
    logic [STATUS_W-1:0] res_status;
    logic [GRANT_W-1:0]  res_granted;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [GRANT_W-1:0]  out_granted_reg;

    assign res_ready = !out_valid_reg || rsp.ready;

    ffa_ctrl #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (req.valid),
        .in_ready      (req.ready),
        .opcode        (req.opcode),
        .request_bytes (req.request_bytes),
        .user_offset   (req.user_offset),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_status    (res_status),
        .res_granted   (res_granted),
        .ctl           (ctl),
        .rd_addr       (rd_addr),
        .sz_waddr      (sz_waddr),
        .sz_wdata      (sz_wdata),
        .nx_waddr      (nx_waddr),
        .nx_wdata      (nx_wdata),
        .rd_size       (rd_size),
        .rd_link       (rd_link)
    );

    ffa_store #(
        .POOL_BYTES (POOL_BYTES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .sz_waddr (sz_waddr),
        .sz_wdata (sz_wdata),
        .nx_waddr (nx_waddr),
        .nx_wdata (nx_wdata),
        .rd_size  (rd_size),
        .rd_link  (rd_link)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_status_reg  <= res_status;
            out_granted_reg <= res_granted;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.granted_offset = out_granted_reg;
endmodule

FILE: design/ffa_store.sv
// ----------------------------------------------------------------------------
// ffa_store
// Block header memories (size and next link) with a registered read port.
// Entry 0 reads as the whole free pool until it is first written.
// ----------------------------------------------------------------------------
module ffa_store #(
    parameter int POOL_BYTES = ffa_pkg::POOL_BYTES_DEF,
    parameter int AW = $clog2(POOL_BYTES),
    parameter int LW = AW + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ffa_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]    rd_addr,
    input  logic [AW-1:0]    sz_waddr,
    input  logic [LW-1:0]    sz_wdata,
    input  logic [AW-1:0]    nx_waddr,
    input  logic [LW-1:0]    nx_wdata,
    output logic [LW-1:0]    rd_size,
    output logic [LW-1:0]    rd_link
);
    import ffa_pkg::*;

    localparam logic [LW-1:0] END_MARK = LW'(POOL_BYTES);

    logic [LW-1:0] size_mem [POOL_BYTES];
    logic [LW-1:0] next_mem [POOL_BYTES];
    logic [LW-1:0] size_q;
    logic [LW-1:0] next_q;
    logic [LW-1:0] next_eff;
    logic          sz0_written_reg;
    logic          nx0_written_reg;
    logic          rd_is0_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.sz_we)
        begin
            size_mem[sz_waddr] <= sz_wdata;
        end
        if (ctl.nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (ctl.rd_en)
        begin
            size_q <= size_mem[rd_addr];
            next_q <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sz0_written_reg <= 1'b0;
            nx0_written_reg <= 1'b0;
            rd_is0_reg      <= 1'b0;
        end
        else
        begin
            if (ctl.sz_we && sz_waddr == '0)
            begin
                sz0_written_reg <= 1'b1;
            end
            if (ctl.nx_we && nx_waddr == '0)
            begin
                nx0_written_reg <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_is0_reg <= (rd_addr == '0);
            end
        end
    end

    assign rd_size  = (rd_is0_reg && !sz0_written_reg) ? END_MARK : size_q;
    assign next_eff = (rd_is0_reg && !nx0_written_reg) ? END_MARK : next_q;
    assign rd_link  = (next_eff >= END_MARK) ? END_MARK : next_eff;
endmodule

FILE: design/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Request sequencer: first-fit walk with split, address-ordered insert and a
// coalescing pass, one header read per cycle.
// ----------------------------------------------------------------------------
`include "first_fit_free_list_allocator_core_assert.svh"

module ffa_ctrl #(
    parameter int POOL_BYTES   = ffa_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    parameter int AW = $clog2(POOL_BYTES),
    parameter int LW = AW + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ffa_pkg::OPCODE_W-1:0]  opcode,
    input  logic [ffa_pkg::REQ_W-1:0]     request_bytes,
    input  logic [ffa_pkg::UOFF_W-1:0]    user_offset,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [ffa_pkg::STATUS_W-1:0]  res_status,
    output logic [ffa_pkg::GRANT_W-1:0]   res_granted,
    output ffa_pkg::mem_ctl_t             ctl,
    output logic [AW-1:0]                 rd_addr,
    output logic [AW-1:0]                 sz_waddr,
    output logic [LW-1:0]                 sz_wdata,
    output logic [AW-1:0]                 nx_waddr,
    output logic [LW-1:0]                 nx_wdata,
    input  logic [LW-1:0]                 rd_size,
    input  logic [LW-1:0]                 rd_link
);
    import ffa_pkg::*;

    localparam int TW = ((LW > REQ_W) ? LW : REQ_W) + 1;
    localparam int CW = LW + 2;
    localparam logic [LW-1:0] END_MARK = LW'(POOL_BYTES);
    localparam logic [TW-1:0] END_T    = TW'(POOL_BYTES);
    localparam logic [TW-1:0] HDR_T    = TW'(HEADER_BYTES);
    localparam logic [CW-1:0] WALK_LIM = CW'(2 * POOL_BYTES + 2);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_AWAIT  = 8'b0000_0010,
        S_ASPLIT = 8'b0000_0100,
        S_FWALK  = 8'b0000_1000,
        S_FLINK  = 8'b0001_0000,
        S_CSTART = 8'b0010_0000,
        S_CWALK  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       prev_reg, prev_next;
    logic [AW-1:0]       blk_reg, blk_next;
    logic [AW-1:0]       nf_reg, nf_next;
    logic [TW-1:0]       total_reg, total_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [LW-1:0]       csize_reg, csize_next;
    logic [LW-1:0]       clink_reg, clink_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [GRANT_W-1:0]  granted_reg, granted_next;

    logic                in_fire;
    logic [TW-1:0]       blk_w;
    logic [TW-1:0]       head_w;
    logic [TW-1:0]       rem_w;
    logic [TW:0]         split_end;
    logic [TW-1:0]       grant_w;
    logic [LW:0]         cur_end;
    logic [LW:0]         merged_w;
    logic [LW-1:0]       merged;
    logic [CW-1:0]       n_inc;
    logic [LW-1:0]       new_link;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE) && res_ready;
    assign res_status  = status_reg;
    assign res_granted = granted_reg;

    assign blk_w     = TW'(user_offset) - HDR_T;
    assign head_w    = TW'(head_reg);
    assign rem_w     = TW'(rd_size) - total_reg;
    assign split_end = (TW + 1)'(cur_reg) + (TW + 1)'(total_reg);
    assign grant_w   = TW'(cur_reg) + HDR_T;
    assign cur_end   = (LW + 1)'(cur_reg) + (LW + 1)'(csize_reg);
    assign merged_w  = (LW + 1)'(csize_reg) + (LW + 1)'(rd_size);
    assign merged    = (merged_w > (LW + 1)'(POOL_BYTES)) ? END_MARK : merged_w[LW-1:0];
    assign n_inc     = n_reg + CW'(1);
    assign new_link  = (cur_end == (LW + 1)'(clink_reg)) ? rd_link : rd_link;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        blk_next     = blk_reg;
        nf_next      = nf_reg;
        total_next   = total_reg;
        n_next       = n_reg;
        csize_next   = csize_reg;
        clink_next   = clink_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        ctl          = '0;
        rd_addr      = '0;
        sz_waddr     = '0;
        sz_wdata     = '0;
        nx_waddr     = '0;
        nx_wdata     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    granted_next = '0;
                    n_next       = '0;
                    if (opcode == OP_ALLOC)
                    begin
                        total_next = TW'(request_bytes) + HDR_T;
                        prev_next  = END_MARK;
                        cur_next   = head_reg;
                        if (request_bytes == '0)
                        begin
                            status_next = ST_IGNORED;
                            state_next  = S_DONE;
                        end
                        else if (head_reg >= END_MARK)
                        begin
                            status_next = ST_NOFIT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            rd_addr    = head_reg[AW-1:0];
                            state_next = S_AWAIT;
                        end
                    end
                    else if (TW'(user_offset) < HDR_T || blk_w >= END_T || blk_w == head_w)
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_DONE;
                    end
                    else if (blk_w < head_w)
                    begin
                        ctl.nx_we  = 1'b1;
                        nx_waddr   = blk_w[AW-1:0];
                        nx_wdata   = head_reg;
                        head_next  = LW'(blk_w);
                        state_next = S_CSTART;
                    end
                    else
                    begin
                        blk_next   = blk_w[AW-1:0];
                        cur_next   = head_reg;
                        ctl.rd_en  = 1'b1;
                        rd_addr    = head_reg[AW-1:0];
                        state_next = S_FWALK;
                    end
                end
            end
            S_AWAIT:
            begin
                if (TW'(rd_size) >= total_reg)
                begin
                    status_next  = ST_OK;
                    granted_next = grant_w[GRANT_W-1:0];
                    if (rem_w >= HDR_T && split_end < (TW + 1)'(POOL_BYTES))
                    begin
                        nf_next    = split_end[AW-1:0];
                        ctl.sz_we  = 1'b1;
                        sz_waddr   = split_end[AW-1:0];
                        sz_wdata   = rem_w[LW-1:0];
                        ctl.nx_we  = 1'b1;
                        nx_waddr   = split_end[AW-1:0];
                        nx_wdata   = rd_link;
                        state_next = S_ASPLIT;
                    end
                    else
                    begin
                        if (prev_reg < END_MARK)
                        begin
                            ctl.nx_we = 1'b1;
                            nx_waddr  = prev_reg[AW-1:0];
                            nx_wdata  = rd_link;
                        end
                        else
                        begin
                            head_next = rd_link;
                        end
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    n_next    = n_inc;
                    if (n_inc >= WALK_LIM || rd_link >= END_MARK)
                    begin
                        status_next = ST_NOFIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = rd_link[AW-1:0];
                    end
                end
            end
            S_ASPLIT:
            begin
                if (prev_reg < END_MARK)
                begin
                    ctl.nx_we = 1'b1;
                    nx_waddr  = prev_reg[AW-1:0];
                    nx_wdata  = LW'(nf_reg);
                end
                else
                begin
                    head_next = LW'(nf_reg);
                end
                ctl.sz_we  = 1'b1;
                sz_waddr   = cur_reg[AW-1:0];
                sz_wdata   = total_reg[LW-1:0];
                state_next = S_DONE;
            end
            S_FWALK:
            begin
                if (n_reg < WALK_LIM && rd_link < LW'(blk_reg))
                begin
                    cur_next  = rd_link;
                    n_next    = n_inc;
                    ctl.rd_en = 1'b1;
                    rd_addr   = rd_link[AW-1:0];
                end
                else if (rd_link == LW'(blk_reg))
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else
                begin
                    ctl.nx_we  = 1'b1;
                    nx_waddr   = blk_reg;
                    nx_wdata   = rd_link;
                    state_next = S_FLINK;
                end
            end
            S_FLINK:
            begin
                ctl.nx_we  = 1'b1;
                nx_waddr   = cur_reg[AW-1:0];
                nx_wdata   = LW'(blk_reg);
                state_next = S_CSTART;
            end
            S_CSTART:
            begin
                n_next   = '0;
                cur_next = head_reg;
                if (head_reg >= END_MARK)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    csize_next = '0;
                    clink_next = head_reg;
                    cur_next   = head_reg;
                    ctl.rd_en  = 1'b1;
                    rd_addr    = head_reg[AW-1:0];
                    state_next = S_CWALK;
                end
            end
            S_CWALK:
            begin
                // The first pass through only loads the head block.
                if (cur_end == (LW + 1)'(clink_reg) && csize_reg != '0)
                begin
                    ctl.sz_we  = 1'b1;
                    sz_waddr   = cur_reg[AW-1:0];
                    sz_wdata   = merged;
                    ctl.nx_we  = 1'b1;
                    nx_waddr   = cur_reg[AW-1:0];
                    nx_wdata   = new_link;
                    csize_next = merged;
                    n_next     = n_inc;
                end
                else
                begin
                    cur_next   = clink_reg;
                    csize_next = rd_size;
                    if (csize_reg != '0)
                    begin
                        n_next = n_inc;
                    end
                end
                clink_next = new_link;
                if (n_next >= WALK_LIM || new_link >= END_MARK)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = new_link[AW-1:0];
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        blk_reg     <= blk_next;
        nf_reg      <= nf_next;
        total_reg   <= total_next;
        n_reg       <= n_next;
        csize_reg   <= csize_next;
        clink_reg   <= clink_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    `FFA_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_reg != S_IDLE)
    `FFA_ASSERT_NEVER(a_no_idle_write, (state_reg == S_IDLE) && !in_fire && (ctl.sz_we || ctl.nx_we))
    `FFA_ASSERT_IMPLIES(a_grant_only_ok, res_valid && res_status != ST_OK, res_granted == '0)
    `FFA_ASSERT_NEVER(a_no_read_when_done, (state_reg == S_DONE) && ctl.rd_en)
endmodule
